@@ rtl/drfs_pkg.sv @@
// drfs_pkg: shared types, codes, constants and the panel setup table
// for the display frame refresh sequencer; no dependencies
package drfs_pkg;

	localparam int PANEL_WIDTH_DEF = 128;
	localparam int PANEL_PAGES_DEF = 8;
	localparam int SETUP_LEN       = 23;

	localparam int CMD_W       = 2;
	localparam int COORD_W     = 9;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 80;
	localparam int PAYLOAD_W   = 64;

	localparam logic [7:0] CTRL_CMD      = 8'h00;
	localparam logic [7:0] CTRL_DATA     = 8'h40;
	localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
	localparam logic [7:0] COL_LOW_CMD   = 8'h00;
	localparam logic [7:0] COL_HIGH_CMD  = 8'h10;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_DRAW    = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_REFRESH = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_SETUP = 2'd1,
		MODE_RUN   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_SINGLE,
		ACT_DRAW,
		ACT_DATA,
		ACT_CLEAR
	} act_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_DRAW_WR,
		ST_SINGLE_OUT,
		ST_BEAT_RD,
		ST_BEAT_LD,
		ST_BEAT_OUT
	} state_t;

	typedef struct packed {
		logic latch_item;
		logic apply_update;
		logic load_single;
		logic rd_draw;
		logic wr_draw;
		logic rd_beat;
		logic load_beat;
		logic beat_next;
		logic finish_data;
		logic clear_start;
		logic clear_step;
	} dp_cmd_t;

	typedef struct packed {
		act_t action;
		logic clear_done;
		logic last_beat;
	} dp_status_t;

	function automatic logic [7:0] setup_byte(input logic [4:0] idx);
		logic [7:0] b;
		case (idx)
			5'd0:    b = 8'hAE;
			5'd1:    b = 8'hD5;
			5'd2:    b = 8'h80;
			5'd3:    b = 8'hA8;
			5'd4:    b = 8'h3F;
			5'd5:    b = 8'hD3;
			5'd6:    b = 8'h00;
			5'd7:    b = 8'h40;
			5'd8:    b = 8'hA1;
			5'd9:    b = 8'hC8;
			5'd10:   b = 8'hDA;
			5'd11:   b = 8'h12;
			5'd12:   b = 8'h81;
			5'd13:   b = 8'hCF;
			5'd14:   b = 8'hD9;
			5'd15:   b = 8'hF1;
			5'd16:   b = 8'hDB;
			5'd17:   b = 8'h30;
			5'd18:   b = 8'hA4;
			5'd19:   b = 8'hA6;
			5'd20:   b = 8'h8D;
			5'd21:   b = 8'h14;
			5'd22:   b = 8'hAF;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/drfs_ram.sv @@
// drfs_ram: generic single-write, single-read ram with registered read data
// no dependencies
module drfs_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 128,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/drfs_ctrl.sv @@
// drfs_ctrl: sequencing state machine of the refresh sequencer
// depends on drfs_pkg (state, command and status types)
module drfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  drfs_pkg::dp_status_t status,
	output drfs_pkg::dp_cmd_t    cmd
);

	drfs_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drfs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			drfs_pkg::ST_CLEAR: begin
				if (status.clear_done) state_nxt = drfs_pkg::ST_IDLE;
			end
			drfs_pkg::ST_IDLE: begin
				if (s_tvalid) state_nxt = drfs_pkg::ST_DECODE;
			end
			drfs_pkg::ST_DECODE: begin
				case (status.action)
					drfs_pkg::ACT_SINGLE: state_nxt = drfs_pkg::ST_SINGLE_OUT;
					drfs_pkg::ACT_DRAW:   state_nxt = drfs_pkg::ST_DRAW_WR;
					drfs_pkg::ACT_DATA:   state_nxt = drfs_pkg::ST_BEAT_LD;
					drfs_pkg::ACT_CLEAR:  state_nxt = drfs_pkg::ST_CLEAR;
					default:              state_nxt = drfs_pkg::ST_IDLE;
				endcase
			end
			drfs_pkg::ST_DRAW_WR:    state_nxt = drfs_pkg::ST_IDLE;
			drfs_pkg::ST_SINGLE_OUT: begin
				if (m_tready) state_nxt = drfs_pkg::ST_IDLE;
			end
			drfs_pkg::ST_BEAT_RD:    state_nxt = drfs_pkg::ST_BEAT_LD;
			drfs_pkg::ST_BEAT_LD:    state_nxt = drfs_pkg::ST_BEAT_OUT;
			drfs_pkg::ST_BEAT_OUT: begin
				if (m_tready) begin
					state_nxt = status.last_beat ? drfs_pkg::ST_IDLE : drfs_pkg::ST_BEAT_RD;
				end
			end
			default: state_nxt = drfs_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			drfs_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
			drfs_pkg::ST_IDLE: begin
				s_tready       = 1'b1;
				cmd.latch_item = s_tvalid;
			end
			drfs_pkg::ST_DECODE: begin
				case (status.action)
					drfs_pkg::ACT_SINGLE: begin
						cmd.apply_update = 1'b1;
						cmd.load_single  = 1'b1;
					end
					drfs_pkg::ACT_DRAW:  cmd.rd_draw     = 1'b1;
					drfs_pkg::ACT_DATA:  cmd.rd_beat     = 1'b1;
					drfs_pkg::ACT_CLEAR: cmd.clear_start = 1'b1;
					default:             cmd.apply_update = 1'b1;
				endcase
			end
			drfs_pkg::ST_DRAW_WR:    cmd.wr_draw = 1'b1;
			drfs_pkg::ST_SINGLE_OUT: m_tvalid = 1'b1;
			drfs_pkg::ST_BEAT_RD:    cmd.rd_beat = 1'b1;
			drfs_pkg::ST_BEAT_LD:    cmd.load_beat = 1'b1;
			drfs_pkg::ST_BEAT_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					cmd.finish_data = status.last_beat;
					cmd.beat_next   = !status.last_beat;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/drfs_dp.sv @@
// drfs_dp: datapath of the refresh sequencer: item register, sequencer state,
// frame store ram, beat counter, clear counter and result register
// depends on drfs_pkg and drfs_ram
module drfs_dp #(
	parameter int PANEL_WIDTH = drfs_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_PAGES = drfs_pkg::PANEL_PAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [drfs_pkg::CMD_W-1:0]          command,
	input  logic [drfs_pkg::COORD_W-1:0]        pos_x,
	input  logic [drfs_pkg::COORD_W-1:0]        pos_y,
	input  logic                                bus_ready,
	input  drfs_pkg::dp_cmd_t                   cmd,
	output drfs_pkg::dp_status_t                status,
	output logic [7:0]                          control_byte,
	output logic [3:0]                          byte_count,
	output logic [drfs_pkg::PAYLOAD_W-1:0]      payload,
	output logic                                last_beat,
	output logic                                param_error
);

	localparam int BEATS    = (PANEL_WIDTH + 7) / 8;
	localparam int DEPTH    = PANEL_PAGES * BEATS;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW       = (BEATS > 1) ? $clog2(BEATS) : 1;
	localparam int LAST_CNT = PANEL_WIDTH - 8 * (BEATS - 1);

	localparam logic [AW-1:0] BEATS_A   = AW'(BEATS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [BW-1:0] LAST_BEAT = BW'(BEATS - 1);
	localparam logic [7:0]    X_LIM     = 8'(PANEL_WIDTH);
	localparam logic [7:0]    Y_LIM     = 8'(PANEL_PAGES * 8);
	localparam logic [3:0]    PAGE_LIM  = 4'(PANEL_PAGES);

	// latched item
	logic [drfs_pkg::CMD_W-1:0]   cmd_q;
	logic [drfs_pkg::COORD_W-1:0] x_q, y_q;
	logic                         ready_q;

	// sequencer state
	drfs_pkg::mode_t mode_q, mode_nxt;
	logic            sdn_q, sdn_nxt;
	logic [4:0]      setup_idx_q, setup_idx_nxt;
	logic [2:0]      page_q, page_nxt;
	logic            pending_q, pending_nxt;
	logic [BW-1:0]   beat_q;
	logic [AW-1:0]   clr_q;

	// single-beat result from decode
	drfs_pkg::act_t              action;
	logic [7:0]                  sg_ctrl;
	logic [3:0]                  sg_cnt;
	logic [drfs_pkg::PAYLOAD_W-1:0] sg_payload;
	logic                        sg_last, sg_err;

	logic                        eff_setup;
	logic [4:0]                  eff_idx;
	logic                        point_bad;
	logic [2:0]                  page_inc;

	logic [AW-1:0]               draw_addr, beat_addr;
	logic [drfs_pkg::PAYLOAD_W-1:0] draw_mask, rd_data;
	logic                        ram_wr_en, ram_rd_en;
	logic [AW-1:0]               ram_wr_addr, ram_rd_addr;
	logic [drfs_pkg::PAYLOAD_W-1:0] ram_wr_data;

	// result register
	logic [7:0]                     ctrl_q;
	logic [3:0]                     count_q;
	logic [drfs_pkg::PAYLOAD_W-1:0] payload_q;
	logic                           last_q;
	logic                           err_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			cmd_q   <= command;
			x_q     <= pos_x;
			y_q     <= pos_y;
			ready_q <= bus_ready;
		end
	end

	assign eff_setup = (mode_q == drfs_pkg::MODE_IDLE) || (mode_q == drfs_pkg::MODE_SETUP);
	assign eff_idx   = (mode_q == drfs_pkg::MODE_IDLE) ? 5'd0 : setup_idx_q;
	assign point_bad = x_q[8] || y_q[8] || (x_q[7:0] >= X_LIM) || (y_q[7:0] >= Y_LIM);

	// decode of the latched item against the sequencer state
	always_comb begin
		action        = drfs_pkg::ACT_NONE;
		mode_nxt      = mode_q;
		sdn_nxt       = sdn_q;
		setup_idx_nxt = setup_idx_q;
		page_nxt      = page_q;
		pending_nxt   = pending_q;
		sg_ctrl       = drfs_pkg::CTRL_CMD;
		sg_cnt        = 4'd1;
		sg_payload    = '0;
		sg_last       = 1'b1;
		sg_err        = 1'b0;
		case (drfs_pkg::cmd_code_t'(cmd_q))
			drfs_pkg::CMD_TICK: begin
				if (ready_q) begin
					if (eff_setup) begin
						if (eff_idx < 5'(drfs_pkg::SETUP_LEN)) begin
							action        = drfs_pkg::ACT_SINGLE;
							sg_payload    = drfs_pkg::PAYLOAD_W'(drfs_pkg::setup_byte(eff_idx));
							mode_nxt      = drfs_pkg::MODE_SETUP;
							setup_idx_nxt = eff_idx + 5'd1;
						end else begin
							mode_nxt    = drfs_pkg::MODE_RUN;
							page_nxt    = 3'd0;
							sdn_nxt     = 1'b0;
							pending_nxt = 1'b1;
						end
					end else if (pending_q) begin
						if (!sdn_q) begin
							action     = drfs_pkg::ACT_SINGLE;
							sg_cnt     = 4'd3;
							sg_payload = drfs_pkg::PAYLOAD_W'({drfs_pkg::COL_HIGH_CMD,
								drfs_pkg::COL_LOW_CMD, drfs_pkg::PAGE_CMD_BASE | {5'd0, page_q}});
							sdn_nxt    = 1'b1;
						end else begin
							action = drfs_pkg::ACT_DATA;
						end
					end
				end
			end
			drfs_pkg::CMD_DRAW: begin
				if (point_bad) begin
					action  = drfs_pkg::ACT_SINGLE;
					sg_cnt  = 4'd0;
					sg_last = 1'b0;
					sg_err  = 1'b1;
				end else begin
					action = drfs_pkg::ACT_DRAW;
				end
			end
			drfs_pkg::CMD_CLEAR: action = drfs_pkg::ACT_CLEAR;
			default: begin
				pending_nxt = 1'b1;
				page_nxt    = 3'd0;
				sdn_nxt     = 1'b0;
			end
		endcase
	end

	assign page_inc = page_q + 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= drfs_pkg::MODE_IDLE;
			sdn_q       <= 1'b0;
			setup_idx_q <= 5'd0;
			page_q      <= 3'd0;
			pending_q   <= 1'b0;
			beat_q      <= '0;
			clr_q       <= '0;
		end else begin
			if (cmd.apply_update) begin
				mode_q      <= mode_nxt;
				sdn_q       <= sdn_nxt;
				setup_idx_q <= setup_idx_nxt;
				page_q      <= page_nxt;
				pending_q   <= pending_nxt;
			end
			if (cmd.finish_data) begin
				sdn_q <= 1'b0;
				if (({1'b0, page_inc} >= PAGE_LIM) || (page_inc == 3'd0)) begin
					page_q    <= 3'd0;
					pending_q <= 1'b0;
				end else begin
					page_q <= page_inc;
				end
			end
			if (cmd.latch_item) begin
				beat_q <= '0;
			end else if (cmd.beat_next) begin
				beat_q <= beat_q + BW'(1);
			end
			if (cmd.clear_start) begin
				clr_q <= '0;
			end else if (cmd.clear_step) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// word address: page row of beats, then column group of eight
	assign draw_addr = AW'(y_q[5:3]) * BEATS_A + AW'(x_q[6:3]);
	assign beat_addr = AW'(page_q) * BEATS_A + AW'(beat_q);
	assign draw_mask = drfs_pkg::PAYLOAD_W'(1) << {x_q[2:0], y_q[2:0]};

	assign ram_rd_en   = cmd.rd_draw || cmd.rd_beat;
	assign ram_rd_addr = cmd.rd_beat ? beat_addr : draw_addr;
	assign ram_wr_en   = cmd.wr_draw || cmd.clear_step;
	assign ram_wr_addr = cmd.wr_draw ? draw_addr : clr_q;
	assign ram_wr_data = cmd.wr_draw ? (rd_data | draw_mask) : '0;

	drfs_ram #(
		.WIDTH (drfs_pkg::PAYLOAD_W),
		.DEPTH (DEPTH),
		.ADDR_W(AW)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(rd_data)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_single) begin
			ctrl_q    <= sg_ctrl;
			count_q   <= sg_cnt;
			payload_q <= sg_payload;
			last_q    <= sg_last;
			err_q     <= sg_err;
		end else if (cmd.load_beat) begin
			ctrl_q    <= drfs_pkg::CTRL_DATA;
			count_q   <= (beat_q == LAST_BEAT) ? 4'(LAST_CNT) : 4'd8;
			payload_q <= rd_data;
			last_q    <= (beat_q == LAST_BEAT);
			err_q     <= 1'b0;
		end
	end

	assign control_byte = ctrl_q;
	assign byte_count   = count_q;
	assign payload      = payload_q;
	assign last_beat    = last_q;
	assign param_error  = err_q;

	assign status.action     = action;
	assign status.clear_done = (clr_q == LAST_ADDR);
	assign status.last_beat  = (beat_q == LAST_BEAT);

endmodule

@@ rtl/display_frame_refresh_sequencer_core.sv @@
// display_frame_refresh_sequencer_core: top level of the frame refresh sequencer
// depends on drfs_pkg, drfs_ctrl, drfs_dp (and drfs_ram through drfs_dp)
// one item at a time; a single-beat result is offered after the decode state and
//   stays offered until taken; an item with no result passes through decode only,
//   a draw point through decode and a ram write state
// a page data transfer runs each beat through a ram read, a load of the result
//   register and an output state that stalls until the result is taken
// clear frame and reset run a clearing pass over all PANEL_PAGES*ceil(PANEL_WIDTH/8)
//   words (128 with default sizes) of the frame store; no item is taken then
// arst_n clears the controller and sequencer state asynchronously
module display_frame_refresh_sequencer_core #(
	parameter int PANEL_WIDTH = drfs_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_PAGES = drfs_pkg::PANEL_PAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input items
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [drfs_pkg::IN_TDATA_W-1:0]     s_tdata,  // pos_x[8:0], pos_y[17:9], bus_ready[18]
	input  logic [drfs_pkg::CMD_W-1:0]          s_tuser,  // command[1:0]
	// result items
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [drfs_pkg::OUT_TDATA_W-1:0]    m_tdata,  // control_byte[7:0], byte_count[11:8],
	                                                      // payload[75:12], zero[79:76]
	output logic                                m_tlast,  // last_beat
	output logic                                m_tuser   // param_error
);

	drfs_pkg::dp_cmd_t    dp_cmd;
	drfs_pkg::dp_status_t dp_status;

	logic [7:0]                     control_byte;
	logic [3:0]                     byte_count;
	logic [drfs_pkg::PAYLOAD_W-1:0] payload;

	// controller: sequences decode, ram access and result handshake
	drfs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (dp_status),
		.cmd     (dp_cmd)
	);

	// datapath: state, frame store and result register
	drfs_dp #(
		.PANEL_WIDTH(PANEL_WIDTH),
		.PANEL_PAGES(PANEL_PAGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (s_tuser),
		.pos_x       (s_tdata[8:0]),
		.pos_y       (s_tdata[17:9]),
		.bus_ready   (s_tdata[18]),
		.cmd         (dp_cmd),
		.status      (dp_status),
		.control_byte(control_byte),
		.byte_count  (byte_count),
		.payload     (payload),
		.last_beat   (m_tlast),
		.param_error (m_tuser)
	);

	// pack result fields, low field first, zero fill to whole bytes
	assign m_tdata = {4'd0, payload, byte_count, control_byte};

endmodule

@@ rtl/drfs_checker.sv @@
// drfs_checker: port-level assertions for the refresh sequencer, bound to the top
// depends on drfs_pkg and display_frame_refresh_sequencer_core
module drfs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [drfs_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tlast,
	input logic                             m_tuser
);

	// a stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result item changed");

	// one item at a time: no input taken while a result is offered
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result pending");

	// error result carries nothing else
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tlast && (m_tdata == '0))
		else $error("error result not zero");

	// normal beats hold 1 to 8 bytes
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[11:8] != 4'd0) && (m_tdata[11:8] <= 4'd8))
		else $error("bad byte count");

	// command transfers are single beats
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser && (m_tdata[7:0] == drfs_pkg::CTRL_CMD) |-> m_tlast)
		else $error("command transfer without last beat");

endmodule

bind display_frame_refresh_sequencer_core drfs_checker u_drfs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);
